>>> rtl/core/fcw_pkg.sv
// fcw_pkg: shared types and constants of the fat12 cluster chain walker
// used by fcw_walker and fat12_cluster_chain_walker; depends on nothing
`default_nettype none

package fcw_pkg;

  localparam int unsigned ClusterW = 12;
  localparam int unsigned AddrW    = 13;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgW     = 7;
  localparam int unsigned RunReset = 64;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_WALK = 2'd1,
    OP_CONT = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_CHAIN  = 2'd0,
    ST_ENDED  = 2'd1,
    ST_PAUSED = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // walk or continue transaction handed to the walker
  typedef struct packed {
    logic                go;
    op_e                 op;
    logic [ClusterW-1:0] start_cluster;
  } cmd_t;

  typedef struct packed {
    logic                strobe;
    logic [ClusterW-1:0] cluster;
    logic [ClusterW-1:0] end_value;
    status_e             status;
    logic                last;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/core/fcw_ram.sv
// fcw_ram: generic single-port synchronous ram with registered read
// no dependencies
`default_nettype none

module fcw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 6144,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

>>> rtl/core/fcw_walker.sv
// fcw_walker: chain walk sequencer, reads two table bytes per cluster from the ram
// depends on fcw_pkg; drives the read address of fcw_ram
`default_nettype none

module fcw_walker
  import fcw_pkg::*;
#(
  parameter int unsigned TABLE_BYTES = 6144,
  parameter int unsigned MAX_RUN     = 64,
  localparam int unsigned AW = (TABLE_BYTES > 1) ? $clog2(TABLE_BYTES) : 1,
  localparam int unsigned CW = $clog2(MAX_RUN + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  input  wire logic [CW-1:0]    lim_i,
  input  wire logic [ByteW-1:0] rdata_i,
  output logic      [AW-1:0]    rd_addr_o,
  output logic                  busy_o,
  output res_t                  res_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD0  = 4'b0010,
    S_RD1  = 4'b0100,
    S_EVAL = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [ClusterW-1:0] cl_q, cl_d;
  logic [CW-1:0]       k_q, k_d;
  logic [CW-1:0]       lim_q, lim_d;
  logic [ByteW-1:0]    b0_q, b0_d;
  logic [ClusterW-1:0] resume_q, resume_d;
  logic                paused_q, paused_d;
  logic                oob_q;
  res_t                res_q, res_d;

  logic [AddrW-1:0]    byte_addr;
  logic                oob;
  logic [ByteW-1:0]    rd_byte;
  logic [ClusterW-1:0] nxt;
  logic [CW:0]         k_inc;

  // byte offset of the first (second) byte holding entry n
  function automatic logic [AddrW-1:0] addr_of(input logic [ClusterW-1:0] n,
                                               input logic second);
    logic [AddrW-1:0] base;
    base = {2'b00, n[ClusterW-1:1]} + {1'b0, n[ClusterW-1:1], 1'b0};
    return base + {{(AddrW-1){1'b0}}, n[0]} + {{(AddrW-1){1'b0}}, second};
  endfunction

  function automatic logic is_term(input logic [ClusterW-1:0] v);
    return (v == '0) || (v >= ClusterW'(12'hFF0));
  endfunction

  assign rd_byte = oob_q ? '0 : rdata_i;
  assign nxt     = cl_q[0] ? {rd_byte, b0_q[7:4]} : {rd_byte[3:0], b0_q};
  assign k_inc   = {1'b0, k_q} + (CW+1)'(1);
  assign oob     = byte_addr >= AddrW'(TABLE_BYTES);
  assign rd_addr_o = byte_addr[AW-1:0];
  assign busy_o  = (state_q != S_IDLE);
  assign res_o   = res_q;

  always_comb begin
    state_d   = state_q;
    cl_d      = cl_q;
    k_d       = k_q;
    lim_d     = lim_q;
    b0_d      = b0_q;
    resume_d  = resume_q;
    paused_d  = paused_q;
    res_d     = res_q;
    res_d.strobe = 1'b0;
    byte_addr = addr_of(cl_q, 1'b0);
    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.go) begin
          unique case (cmd_i.op)
            OP_WALK: begin
              paused_d = 1'b0;
              if (is_term(cmd_i.start_cluster)) begin
                res_d = '{strobe: 1'b1, cluster: cmd_i.start_cluster, end_value: '0,
                          status: ST_EMPTY, last: 1'b1};
              end else begin
                cl_d    = cmd_i.start_cluster;
                k_d     = '0;
                lim_d   = lim_i;
                state_d = S_RD0;
              end
            end
            OP_CONT: begin
              if (paused_q) begin
                paused_d = 1'b0;
                cl_d     = resume_q;
                k_d      = '0;
                lim_d    = lim_i;
                state_d  = S_RD0;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD0: begin
        state_d = S_RD1;
      end
      S_RD1: begin
        byte_addr = addr_of(cl_q, 1'b1);
        b0_d      = rd_byte;
        state_d   = S_EVAL;
      end
      S_EVAL: begin
        if (is_term(nxt)) begin
          res_d = '{strobe: 1'b1, cluster: cl_q, end_value: nxt,
                    status: ST_ENDED, last: 1'b1};
          state_d = S_IDLE;
        end else if (k_inc >= {1'b0, lim_q}) begin
          res_d = '{strobe: 1'b1, cluster: cl_q, end_value: '0,
                    status: ST_PAUSED, last: 1'b1};
          resume_d = nxt;
          paused_d = 1'b1;
          state_d  = S_IDLE;
        end else begin
          res_d = '{strobe: 1'b1, cluster: cl_q, end_value: '0,
                    status: ST_CHAIN, last: 1'b0};
          k_d       = k_inc[CW-1:0];
          cl_d      = nxt;
          // overlap: first byte of the next entry is fetched right away
          byte_addr = addr_of(nxt, 1'b0);
          state_d   = S_RD1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      resume_q <= '0;
      paused_q <= 1'b0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      resume_q <= resume_d;
      paused_q <= paused_d;
      res_q    <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cl_q  <= cl_d;
    k_q   <= k_d;
    lim_q <= lim_d;
    b0_q  <= b0_d;
    oob_q <= oob;
  end

endmodule

`default_nettype wire

>>> rtl/core/fat12_cluster_chain_walker.sv
// fat12_cluster_chain_walker: top level, run length register, load path, ram and walker
// depends on fcw_pkg, fcw_ram and fcw_walker
//
// usage:
//   command channel: a transaction is taken at a rising edge with start high and
//   busy low. operation 0 writes byte_value_i at byte_address_i (addresses at or
//   beyond the table size are dropped), 1 walks the chain from start_cluster_i,
//   2 resumes a walk paused at the run limit, 3 does nothing.
//   result channel: each result is on cluster_o, end_value_o, status_o, last_o for
//   one cycle with strobe_o high; the receiver cannot stall, it must take it.
//   config channel: cfg_data_i is written to the run length register when
//   cfg_valid_i and cfg_ready_o are high; write it only while the block is idle.
// timing:
//   a load leaves busy low. an empty start gives its result the cycle
//   after the transaction. a walk keeps busy high while it reads: two
//   table byte reads per cluster on the single ram port, with the first
//   byte of the next entry fetched in the cycle its address is known.
//   the walker passes through RD0, RD1 and EVAL for the first cluster and
//   RD1, EVAL for each later one, and gives one result per cluster.
// reset: no walk is paused and the run length is 64; table contents are
//   undefined until loaded and need no clearing pass.
`default_nettype none

module fat12_cluster_chain_walker
  import fcw_pkg::*;
#(
  parameter int unsigned TABLE_BYTES = 6144,
  parameter int unsigned MAX_RUN     = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          operation_i,
  input  wire logic [AddrW-1:0]    byte_address_i,
  input  wire logic [ByteW-1:0]    byte_value_i,
  input  wire logic [ClusterW-1:0] start_cluster_i,
  output logic                     strobe_o,
  output logic [ClusterW-1:0]      cluster_o,
  output logic [ClusterW-1:0]      end_value_o,
  output logic [1:0]               status_o,
  output logic                     last_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgW-1:0]     cfg_data_i
);

  localparam int unsigned AW = (TABLE_BYTES > 1) ? $clog2(TABLE_BYTES) : 1;
  localparam int unsigned CW = $clog2(MAX_RUN + 1);

  logic [CfgW-1:0]  max_run_q;
  logic [CfgW-1:0]  lim_full;
  logic [CW-1:0]    lim;
  logic             accept;
  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [AW-1:0]    walk_addr;
  logic [ByteW-1:0] ram_rdata;
  cmd_t             cmd;
  res_t             res;
  op_e              op;

  assign op          = op_e'(operation_i);
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_run_q <= CfgW'(RunReset);
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_run_q <= cfg_data_i;
    end
  end

  // zero acts as one, anything above the cap acts as the cap
  always_comb begin
    priority if (max_run_q == '0) begin
      lim_full = CfgW'(1);
    end else if (max_run_q > CfgW'(MAX_RUN)) begin
      lim_full = CfgW'(MAX_RUN);
    end else begin
      lim_full = max_run_q;
    end
  end
  assign lim = lim_full[CW-1:0];

  assign ram_we   = accept && (op == OP_LOAD) && (byte_address_i < AddrW'(TABLE_BYTES));
  assign ram_addr = ram_we ? byte_address_i[AW-1:0] : walk_addr;

  assign cmd.go            = accept && ((op == OP_WALK) || (op == OP_CONT));
  assign cmd.op            = op;
  assign cmd.start_cluster = start_cluster_i;

  fcw_ram #(
    .WIDTH(ByteW),
    .DEPTH(TABLE_BYTES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(byte_value_i),
    .rdata_o(ram_rdata)
  );

  fcw_walker #(
    .TABLE_BYTES(TABLE_BYTES),
    .MAX_RUN    (MAX_RUN)
  ) u_walker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .lim_i    (lim),
    .rdata_i  (ram_rdata),
    .rd_addr_o(walk_addr),
    .busy_o   (busy),
    .res_o    (res)
  );

  assign strobe_o    = res.strobe;
  assign cluster_o   = res.cluster;
  assign end_value_o = res.end_value;
  assign status_o    = res.status;
  assign last_o      = res.last;

endmodule

`default_nettype wire
